// ----- hdl/fbpa_pkg.sv -----
package fbpa_pkg;

	// Defaults for the top-level parameters.
	localparam int NUM_BLOCKS_DEF    = 256;
	localparam int POINTER_BYTES_DEF = 4;

	// Field widths fixed by the interface.
	localparam int ADDR_W   = 32;
	localparam int BSIZE_W  = 16;
	localparam int BCOUNT_W = 9;
	localparam int FREE_W   = 9;
	// A rounded block size can reach one past the 16-bit range.
	localparam int SZ_W     = BSIZE_W + 1;

	// Request modes.
	localparam logic [1:0] MODE_ALLOC         = 2'd0;
	localparam logic [1:0] MODE_FREE_CHECKED  = 2'd1;
	localparam logic [1:0] MODE_FREE_UNCHECKED = 2'd2;
	localparam logic [1:0] MODE_REBUILD       = 2'd3;

	// Response status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
	localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] block_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
		logic [FREE_W-1:0] blocks_free;
	} rsp_t;

endpackage

// ----- hdl/fixed_block_pool_allocator_top.sv -----
// Fixed-size block pool allocator. The free list of block indices lives in a one-port-read,
// one-port-write RAM as a LIFO chain; the head index and the free count are registers. An
// allocate that grants a block passes through these states: S_SIZE_A and S_SIZE_B derive the
// rounded block size, S_ALLOC_RD reads the link of the head block, S_ALLOC_FIN forms the
// granted address; an allocate on an empty pool answers from S_ALLOC_RD. A free runs the
// 32-step restoring divider that turns the byte offset into a block index. A rebuild
// writes one link per cycle over the clamped pool size. After reset the block runs the same
// rebuild over min(256, NUM_BLOCKS) entries, during which it stalls requests; configuration
// writes are taken at all times but must only be issued while idle. A response waits in an
// output register, so the next request is taken while it is held.
module fixed_block_pool_allocator_top #(
	parameter int NUM_BLOCKS    = fbpa_pkg::NUM_BLOCKS_DEF,
	parameter int POINTER_BYTES = fbpa_pkg::POINTER_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  fbpa_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output fbpa_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
	localparam int NW     = (CNT_W > fbpa_pkg::BCOUNT_W) ? CNT_W : fbpa_pkg::BCOUNT_W;
	localparam int SZ_W   = fbpa_pkg::SZ_W;
	localparam int AW     = fbpa_pkg::ADDR_W;
	localparam int PB_W   = 4;
	// Reciprocal for the round-up division by the pointer size; exact for sizes below 2^17.
	localparam int SH     = 20;
	localparam int RECIP  = (2 ** SH + POINTER_BYTES - 1) / POINTER_BYTES;
	localparam int LIM_W  = SZ_W + NW;
	localparam int CMP_W  = (LIM_W > AW) ? LIM_W : AW;
	localparam int RST_N  = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REBUILD,
		S_SIZE_A,
		S_SIZE_B,
		S_ALLOC_RD,
		S_ALLOC_FIN,
		S_FREE_CHK,
		S_FREE_DIV,
		S_FREE_PUSH,
		S_DONE
	} state_t;

	state_t state_q;

	logic [AW-1:0]                     base_q;
	logic [fbpa_pkg::BSIZE_W-1:0]      bsize_q;
	logic [fbpa_pkg::BCOUNT_W-1:0]     bcount_q;

	logic [1:0]                        mode_q;
	logic [AW-1:0]                     addr_q;
	logic [IDX_W-1:0]                  head_q;
	logic [CNT_W-1:0]                  free_q;
	logic [CNT_W-1:0]                  cursor_q;
	logic [CNT_W-1:0]                  n_q;
	logic                              auto_q;
	logic [SZ_W+SH-1:0]                prod_q;
	logic [SZ_W-1:0]                   size_q;
	logic [IDX_W+SZ_W-1:0]             mul_q;
	logic [LIM_W-1:0]                  limit_q;
	logic [AW-1:0]                     offset_q;
	logic                              below_q;
	logic [AW-1:0]                     quo_q;
	logic [SZ_W-1:0]                   rem_q;
	logic [4:0]                        cnt_q;
	fbpa_pkg::rsp_t                    res_q;
	fbpa_pkg::rsp_t                    rsp_q;
	logic                              rsp_valid_q;

	logic [NW-1:0]                     bc_ext;
	logic [CNT_W-1:0]                  n_eff;
	logic [SZ_W-1:0]                   bs_ext;
	logic [SZ_W-1:0]                   bs_min;
	logic [SZ_W-1:0]                   bs_up;
	logic [CNT_W-1:0]                  cur_inc;
	logic [SZ_W:0]                     rem_sh;
	logic                              rem_ge;
	logic                              bad;
	logic                              req_acc;
	logic                              rsp_free;

	logic                              ram_we;
	logic [IDX_W-1:0]                  ram_waddr;
	logic [IDX_W-1:0]                  ram_wdata;
	logic [IDX_W-1:0]                  ram_rdata;

	fbpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NUM_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		bc_ext  = NW'(bcount_q);
		n_eff   = (bc_ext > NW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bc_ext);
		bs_ext  = SZ_W'(bsize_q);
		bs_min  = (bs_ext < SZ_W'(POINTER_BYTES)) ? SZ_W'(POINTER_BYTES) : bs_ext;
		bs_up   = bs_min + SZ_W'(POINTER_BYTES - 1);
		cur_inc = cursor_q + 1'b1;
		rem_sh  = {rem_q, quo_q[AW-1]};
		rem_ge  = (rem_sh >= {1'b0, size_q});
		bad     = (addr_q == '0)
			|| ((mode_q == fbpa_pkg::MODE_FREE_CHECKED)
				&& (below_q || (CMP_W'(offset_q) >= CMP_W'(limit_q))))
			|| (quo_q >= AW'(NUM_BLOCKS))
			|| (free_q >= CNT_W'(NUM_BLOCKS));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cursor_q[IDX_W-1:0];
		ram_wdata = '0;
		if (state_q == S_REBUILD && cursor_q < n_q) begin
			ram_we    = 1'b1;
			ram_wdata = (cur_inc < n_q) ? cur_inc[IDX_W-1:0] : '0;
		end else if (state_q == S_FREE_PUSH && !bad) begin
			ram_we    = 1'b1;
			ram_waddr = quo_q[IDX_W-1:0];
			ram_wdata = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			bsize_q     <= fbpa_pkg::BSIZE_W'(4);
			bcount_q    <= fbpa_pkg::BCOUNT_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fbpa_pkg::REG_BASE_ADDRESS: base_q   <= cfg_data;
				fbpa_pkg::REG_BLOCK_SIZE:   bsize_q  <= cfg_data[fbpa_pkg::BSIZE_W-1:0];
				fbpa_pkg::REG_BLOCK_COUNT:  bcount_q <= cfg_data[fbpa_pkg::BCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_REBUILD;
			head_q      <= '0;
			free_q      <= '0;
			cursor_q    <= '0;
			n_q         <= CNT_W'(RST_N);
			auto_q      <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			// A finished transaction refills the output register as the old one leaves.
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						mode_q <= req.mode;
						addr_q <= req.block_address;
						if (req.mode == fbpa_pkg::MODE_REBUILD) begin
							n_q     <= n_eff;
							auto_q  <= 1'b0;
							state_q <= S_REBUILD;
						end else begin
							state_q <= S_SIZE_A;
						end
					end
				end
				S_REBUILD: begin
					if (cursor_q < n_q) begin
						cursor_q <= cur_inc;
					end else begin
						cursor_q <= '0;
						head_q   <= '0;
						free_q   <= n_q;
						res_q.status          <= fbpa_pkg::STATUS_OK;
						res_q.granted_address <= '0;
						res_q.blocks_free     <= fbpa_pkg::FREE_W'(n_q);
						state_q  <= auto_q ? S_IDLE : S_DONE;
					end
				end
				S_SIZE_A: begin
					prod_q  <= (SZ_W + SH)'(bs_up) * (SZ_W + SH)'(RECIP);
					state_q <= S_SIZE_B;
				end
				S_SIZE_B: begin
					size_q  <= SZ_W'(prod_q[SZ_W+SH-1:SH] * PB_W'(POINTER_BYTES));
					state_q <= (mode_q == fbpa_pkg::MODE_ALLOC) ? S_ALLOC_RD : S_FREE_CHK;
				end
				S_ALLOC_RD: begin
					if (free_q == '0) begin
						res_q.status          <= fbpa_pkg::STATUS_EMPTY;
						res_q.granted_address <= '0;
						res_q.blocks_free     <= '0;
						state_q <= S_DONE;
					end else begin
						mul_q   <= head_q * size_q;
						state_q <= S_ALLOC_FIN;
					end
				end
				S_ALLOC_FIN: begin
					head_q <= ram_rdata;
					free_q <= free_q - 1'b1;
					res_q.status          <= fbpa_pkg::STATUS_OK;
					res_q.granted_address <= base_q + AW'(mul_q);
					res_q.blocks_free     <= fbpa_pkg::FREE_W'(free_q - 1'b1);
					state_q <= S_DONE;
				end
				S_FREE_CHK: begin
					offset_q <= addr_q - base_q;
					quo_q    <= addr_q - base_q;
					below_q  <= (addr_q < base_q);
					limit_q  <= size_q * NW'(n_eff);
					rem_q    <= '0;
					cnt_q    <= '0;
					state_q  <= S_FREE_DIV;
				end
				S_FREE_DIV: begin
					// One quotient bit per cycle, most significant first.
					rem_q <= rem_ge ? SZ_W'(rem_sh - {1'b0, size_q}) : rem_sh[SZ_W-1:0];
					quo_q <= {quo_q[AW-2:0], rem_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						state_q <= S_FREE_PUSH;
					end
				end
				S_FREE_PUSH: begin
					res_q.granted_address <= '0;
					if (bad) begin
						res_q.status      <= fbpa_pkg::STATUS_BAD_ADDR;
						res_q.blocks_free <= fbpa_pkg::FREE_W'(free_q);
					end else begin
						head_q <= quo_q[IDX_W-1:0];
						free_q <= free_q + 1'b1;
						res_q.status      <= fbpa_pkg::STATUS_OK;
						res_q.blocks_free <= fbpa_pkg::FREE_W'(free_q + 1'b1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// The free list can never count more entries than the link memory holds.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(NUM_BLOCKS))
		else $error("free count exceeds pool depth");

	// An accepted request keeps the request side stalled until its work is done.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("request side not stalled after acceptance");

	// The rebuild cursor is parked at zero whenever no rebuild is in progress.
	a_cursor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cursor_q == '0))
		else $error("rebuild cursor not cleared while idle");

	// A failed response (any status other than OK) carries a zero address.
	a_empty_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != fbpa_pkg::STATUS_OK) |-> (rsp.granted_address == '0))
		else $error("address granted on a failed transaction");
`endif

endmodule

// ----- hdl/fbpa_ram.sv -----
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- test/fbpa_checker.sv -----
module fbpa_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_stall,
	input  fbpa_pkg::req_t              req,
	input  logic                        rsp_valid,
	input  logic                        rsp_stall,
	input  fbpa_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [fbpa_pkg::ADDR_W-1:0] cfg_data,
	output int                          errors,
	output int                          outstanding
);
	import fbpa_pkg::*;

	localparam int DEPTH = NUM_BLOCKS_DEF;
	localparam int PTR   = POINTER_BYTES_DEF;

	logic [ADDR_W-1:0]   base_q;
	logic [BSIZE_W-1:0]  bsize_q;
	logic [BCOUNT_W-1:0] bcount_q;
	logic [FREE_W-1:0]   link_mem [DEPTH];
	logic [FREE_W-1:0]   head_q;
	logic [FREE_W-1:0]   avail_q;
	rsp_t                due_rsp [$];
	rsp_t                want;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_val);
		if (errors < 100)
			$display("mismatch: %s got %0h wanted %0h", what, got, exp_val);
		errors++;
	endtask

	function automatic logic [SZ_W-1:0] stride();
		int s;
		s = (bsize_q < PTR) ? PTR : int'(bsize_q);
		return SZ_W'(((s + PTR - 1) / PTR) * PTR);
	endfunction

	function automatic int pool_blocks();
		return (bcount_q > DEPTH) ? DEPTH : int'(bcount_q);
	endfunction

	function automatic void relink();
		int n;
		n = pool_blocks();
		for (int i = 0; i < n; i++)
			link_mem[i] = (i + 1 < n) ? FREE_W'(i + 1) : '0;
		head_q  = '0;
		avail_q = FREE_W'(n);
	endfunction

	function automatic rsp_t pool_answer(input req_t r);
		rsp_t              o;
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] slot;
		logic [63:0]       span;
		logic [SZ_W-1:0]   sz;
		logic              reject;
		sz = stride();
		o = '0;
		o.status = STATUS_OK;
		case (r.mode)
		MODE_ALLOC: begin
			if (avail_q == 0) begin
				o.status = STATUS_EMPTY;
			end else begin
				slot = ADDR_W'(head_q % DEPTH);
				o.granted_address = base_q + slot * ADDR_W'(sz);
				head_q = link_mem[slot];
				avail_q = avail_q - 1'b1;
			end
		end
		MODE_REBUILD: relink();
		default: begin
			offset = r.block_address - base_q;
			slot = offset / ADDR_W'(sz);
			reject = (r.block_address == '0);
			if (r.mode == MODE_FREE_CHECKED) begin
				// The upper bound is formed in 64 bits so that it never wraps.
				span = 64'(sz) * 64'(pool_blocks());
				if (r.block_address < base_q || 64'(offset) >= span)
					reject = 1'b1;
			end
			if (slot >= DEPTH || avail_q >= DEPTH)
				reject = 1'b1;
			if (reject) begin
				o.status = STATUS_BAD_ADDR;
			end else begin
				link_mem[slot] = head_q;
				head_q = FREE_W'(slot);
				avail_q = avail_q + 1'b1;
			end
		end
		endcase
		o.blocks_free = avail_q;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   = '0;
			bsize_q  = BSIZE_W'(4);
			bcount_q = BCOUNT_W'(256);
			relink();
			due_rsp.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			// Responses are checked before this edge's request is predicted.
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					report("response transaction with none pending", 32'(rsp.blocks_free), 0);
				end else begin
					want = due_rsp.pop_front();
					if (rsp.status != want.status)
						report("status", 32'(rsp.status), 32'(want.status));
					if (rsp.granted_address != want.granted_address)
						report("granted_address", rsp.granted_address, want.granted_address);
					if (rsp.blocks_free != want.blocks_free)
						report("blocks_free", 32'(rsp.blocks_free), 32'(want.blocks_free));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_BASE_ADDRESS: base_q = cfg_data;
				REG_BLOCK_SIZE:   bsize_q = cfg_data[BSIZE_W-1:0];
				REG_BLOCK_COUNT:  bcount_q = cfg_data[BCOUNT_W-1:0];
				default: ;
				endcase
			end
			if (req_valid && !req_stall)
				due_rsp.push_back(pool_answer(req));
			outstanding = due_rsp.size();
		end
	end

endmodule

// ----- test/tb_fixed_block_pool_allocator_top.sv -----
module tb_fixed_block_pool_allocator_top;
	import fbpa_pkg::*;

	localparam int DEPTH       = NUM_BLOCKS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 80;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [ADDR_W-1:0] cfg_data;

	int                errors;
	int                outstanding;
	int                cycles;
	logic              calm;
	logic              squeeze;

	// Address arithmetic of the current pool, used only to aim the frees.
	logic [ADDR_W-1:0] cur_base;
	int                cur_stride;
	int                cur_blocks;
	logic [ADDR_W-1:0] held_q [$];

	fixed_block_pool_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fbpa_checker u_pool_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Granted blocks are collected so that some of the frees return a real block.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && rsp.status == STATUS_OK &&
		    rsp.granted_address != '0)
			held_q.push_back(rsp.granted_address);
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze) begin
				// A long hold-off fills the block so that it stalls its input.
				squeeze = 1'b0;
				rsp_stall <= 1'b1;
				repeat (400) @(negedge clk);
			end
			rsp_stall <= !calm && ($urandom_range(99) < 13);
		end
	end

	function automatic int rounded(input logic [BSIZE_W-1:0] s);
		int v;
		v = (s < POINTER_BYTES_DEF) ? POINTER_BYTES_DEF : int'(s);
		return ((v + POINTER_BYTES_DEF - 1) / POINTER_BYTES_DEF) * POINTER_BYTES_DEF;
	endfunction

	// Entered at a falling edge; returns at a falling edge once the request has been accepted.
	task automatic offer(input logic [1:0] m, input logic [ADDR_W-1:0] a);
		while (!calm && $urandom_range(99) < 13) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.mode <= m;
		req.block_address <= a;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic setup_pool(input logic [ADDR_W-1:0] b, input logic [BSIZE_W-1:0] s,
			input logic [BCOUNT_W-1:0] n);
		drain();
		set_reg(REG_BASE_ADDRESS, b);
		set_reg(REG_BLOCK_SIZE, {16'($urandom), s});
		set_reg(REG_BLOCK_COUNT, {23'($urandom), n});
		cfg_valid <= 1'b0;
		cur_base = b;
		cur_stride = rounded(s);
		cur_blocks = (n > DEPTH) ? DEPTH : int'(n);
		held_q.delete();
	endtask

	task automatic random_item();
		logic [1:0]        m;
		logic [ADDR_W-1:0] a;
		int                r;
		int                k;
		r = $urandom_range(99);
		a = $urandom;
		if (r < 4) begin
			m = MODE_REBUILD;
		end else if (r < 48) begin
			m = MODE_ALLOC;
		end else begin
			m = ($urandom_range(1) == 0) ? MODE_FREE_CHECKED : MODE_FREE_UNCHECKED;
			r = $urandom_range(9);
			if (r < 5 && held_q.size() > 0) begin
				k = $urandom_range(held_q.size() - 1);
				a = held_q[k];
				held_q.delete(k);
				if ($urandom_range(3) == 0)
					a = a + $urandom_range(cur_stride - 1);
			end else if (r < 8) begin
				a = cur_base + $urandom_range(cur_blocks) * cur_stride +
				    $urandom_range(cur_stride - 1);
			end else begin
				case ($urandom_range(4))
				0: a = '0;
				1: a = cur_base - 1;
				2: a = cur_base + cur_blocks * cur_stride;
				3: a = cur_base + DEPTH * cur_stride;
				default: ;
				endcase
			end
		end
		offer(m, a);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE_ADDRESS;
		cfg_data = '0;
		calm = 1'b0;
		squeeze = 1'b0;
		cur_base = '0;
		cur_stride = 4;
		cur_blocks = DEPTH;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The pool starts full, so the first valid free finds the list full.
		offer(MODE_FREE_CHECKED, 32'h0);
		offer(MODE_FREE_UNCHECKED, 32'h10);
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_FREE_CHECKED, 32'h4);
		offer(MODE_FREE_CHECKED, 32'h4);
		offer(MODE_FREE_CHECKED, 32'h400);
		offer(MODE_FREE_UNCHECKED, 32'h400);
		offer(MODE_FREE_UNCHECKED, 32'hFFFF_FFFF);
		offer(MODE_FREE_CHECKED, 32'h7);
		offer(MODE_REBUILD, 32'h0);

		// Two blocks of eight bytes: empty pool, range limits and truncation.
		setup_pool(32'h100, 16'd5, 9'd2);
		offer(MODE_REBUILD, 32'hFFFF_FFFF);
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_FREE_CHECKED, 32'hFF);
		offer(MODE_FREE_UNCHECKED, 32'hFF);
		offer(MODE_FREE_CHECKED, 32'h110);
		offer(MODE_FREE_UNCHECKED, 32'h110);
		offer(MODE_FREE_CHECKED, 32'h10B);
		// A new size changes the address arithmetic before any rebuild.
		drain();
		set_reg(REG_BLOCK_SIZE, 32'd16);
		cfg_valid <= 1'b0;
		cur_stride = 16;
		offer(MODE_ALLOC, 32'h0);
		offer(MODE_FREE_CHECKED, 32'h110);
		offer(MODE_REBUILD, 32'h0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: setup_pool(32'hFFFF_FF00, 16'd3, 9'd8);
			1: setup_pool(32'h0000_1000, 16'hFFFF, 9'd256);
			2: setup_pool(32'h0, 16'd13, 9'd0);
			3: setup_pool($urandom, 16'd8, 9'd300);
			4: setup_pool(32'hFFFF_FFFF, 16'd1, 9'd1);
			5: setup_pool(32'hFFFF_0000, 16'hFFFF, 9'h1FF);
			default: setup_pool($urandom,
				($urandom_range(9) < 7) ? 16'($urandom_range(40, 1)) : 16'($urandom),
				($urandom_range(9) < 6) ? 9'($urandom_range(12, 1)) :
				($urandom_range(9) < 7) ? 9'($urandom) : 9'd256);
			endcase
			calm = (p == 3);
			offer(MODE_REBUILD, $urandom);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 20)
					squeeze = 1'b1;
				random_item();
			end
		end
		calm = 1'b0;

		drain();
		repeat (40) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/fbpa_pkg.sv
hdl/fbpa_ram.sv
hdl/fixed_block_pool_allocator_top.sv
test/fbpa_checker.sv
test/tb_fixed_block_pool_allocator_top.sv
